>>> sv/assert_macros.svh
// Assertion macros included by biquad_iir_filter_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define BQD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that an expression never holds outside reset.
`define BQD_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> sv/bqd_pkg.sv
// Package: types and constants of the biquad IIR filter.
package bqd_pkg;

    localparam int COEF_ONE      = 65536;  // 1.0 in Q3.16
    localparam int COEF_ONE_BITS = 18;     // signed width that holds 1.0
    localparam int PADDR_W       = 5;
    localparam int REG_IDX_W     = 3;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B0     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B1     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_B2     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A0     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_A1     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_A2     = 3'd6;

    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // Product terms: b0*x, b1*x1, b2*x2, a1*y1, a2*y2.
    localparam logic [2:0] TERM_B0   = 3'd0;
    localparam logic [2:0] TERM_B1   = 3'd1;
    localparam logic [2:0] TERM_B2   = 3'd2;
    localparam logic [2:0] TERM_A1   = 3'd3;
    localparam logic [2:0] TERM_A2   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

>>> sv/bqd_serial_mul.sv
// Bit-serial signed multiplier: one sample bit per cycle, LSB first.
module bqd_serial_mul
    import bqd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int CW          = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [CW-1:0]          i_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output t_unit_stat                    o_stat,
    output logic signed [SAMPLE_BITS+CW-1:0] o_product
);

    localparam int CNT_W = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic signed [CW-1:0]   r_coef;
    logic signed [CW+1:0]   r_hi;
    logic [SAMPLE_BITS-1:0] r_lo;

    logic                   last;
    logic signed [CW+1:0]   addend;
    logic signed [CW+1:0]   sum;
    logic signed [CW+1:0]   n_hi;
    logic [SAMPLE_BITS-1:0] n_lo;

    always_comb begin
        last   = (r_cnt == CNT_W'(SAMPLE_BITS - 1));
        addend = r_lo[0] ? (CW+2)'(r_coef) : '0;
        // sign bit of the sample carries negative weight
        sum    = last ? (r_hi - addend) : (r_hi + addend);
        n_hi   = sum >>> 1;
        n_lo   = {sum[0], r_lo[SAMPLE_BITS-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= !last;
            r_done <= last;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_coef <= i_coef;
            r_hi   <= '0;
            r_lo   <= i_sample;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_stat    = '{busy: r_busy, done: r_done};
    assign o_product = {r_hi[CW-1:0], r_lo};

endmodule

>>> sv/bqd_serial_div.sv
// Restoring unsigned divider: one quotient bit per cycle.
module bqd_serial_div
    import bqd_pkg::*;
#(
    parameter int NUM_W = 38,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_unit_stat       o_stat,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_den;

    logic             last;
    logic [DEN_W:0]   shifted;
    logic             ge;

    always_comb begin
        last    = (r_cnt == CNT_W'(NUM_W - 1));
        shifted = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
        ge      = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= !last;
            r_done <= last;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? (shifted - {1'b0, r_den}) : shifted;
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_quot;

endmodule

>>> sv/biquad_iir_filter_top.sv
// Biquad IIR filter, direct form I: APB registers, sequencer, history, output register.
//
// Input channel (i_in_valid / o_in_ready) takes one word: i_action and i_sample_in.
// Output channel (o_out_valid / i_out_ready) gives o_sample_out and o_saturated.
// A filter word computes y = (b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2) / a0 with one
// shared bit-serial multiplier (five products, one after another) and a
// restoring divider (ACC_W = min(SAMPLE_BITS+CW+2, 64), CW = max(COEF_BITS, 18));
// an a0 of zero divides by 1.0. One word is in work at a time.
// With filtering disabled a word passes through to the output register; a clear
// word zeroes the history and gives no result.
// The result sits in an output register; a stalled receiver holds it there and
// the next word is still accepted, its result waiting until the register frees.
// Reset (synchronous, active low) sets b0 = a0 = 1.0, other coefficients to 0,
// disables filtering and zeroes the history. Registers are written over APB at
// byte address 4*index; pready is always high.
module biquad_iir_filter_top
    import bqd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_saturated
);

    localparam int CW     = (COEF_BITS > COEF_ONE_BITS) ? COEF_BITS : COEF_ONE_BITS;
    localparam int PW     = SAMPLE_BITS + CW;
    localparam int ACC_W  = (PW + 2 > 64) ? 64 : PW + 2;
    localparam int SW     = ACC_W + 1;
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [ACC_W-1:0] POS_LIM = {{(ACC_W-SAMPLE_BITS+1){1'b0}},
                                            {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [ACC_W-1:0] NEG_LIM = POS_LIM + 1'b1;

    // configuration registers
    logic                 r_enable;
    logic signed [CW-1:0] r_b0, r_b1, r_b2, r_a0, r_a1, r_a2;

    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  cfg_idx;
    logic signed [CW-1:0]  cfg_coef;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[PADDR_W-1:2];
    assign cfg_coef = CW'($signed(pwdata[COEF_BITS-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_b0     <= CW'(COEF_ONE);
            r_b1     <= '0;
            r_b2     <= '0;
            r_a0     <= CW'(COEF_ONE);
            r_a1     <= '0;
            r_a2     <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ENABLE: r_enable <= pwdata[0];
                REG_B0:     r_b0     <= cfg_coef;
                REG_B1:     r_b1     <= cfg_coef;
                REG_B2:     r_b2     <= cfg_coef;
                REG_A0:     r_a0     <= cfg_coef;
                REG_A1:     r_a1     <= cfg_coef;
                REG_A2:     r_a2     <= cfg_coef;
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ENABLE: prdata = {31'd0, r_enable};
            REG_B0:     prdata = 32'(r_b0);
            REG_B1:     prdata = 32'(r_b1);
            REG_B2:     prdata = 32'(r_b2);
            REG_A0:     prdata = 32'(r_a0);
            REG_A1:     prdata = 32'(r_a1);
            REG_A2:     prdata = 32'(r_a2);
            default:    prdata = '0;
        endcase
    end

    // sequencer and datapath
    t_state                        r_state;
    logic                          r_kick;
    logic [2:0]                    r_term;
    logic signed [SAMPLE_BITS-1:0] r_x, r_x1, r_x2, r_y1, r_y2;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_qneg;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic                          r_sat;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_sat;

    logic                          in_acc;
    logic                          out_free;
    logic signed [CW-1:0]          op_coef;
    logic signed [SAMPLE_BITS-1:0] op_sample;
    logic                          op_sub;
    t_unit_stat                    mul_stat;
    t_unit_stat                    div_stat;
    logic signed [PW-1:0]          mul_product;
    logic signed [SW-1:0]          sum;
    logic signed [ACC_W-1:0]       n_acc;
    logic signed [CW-1:0]          dv;
    logic [CW-1:0]                 den_mag;
    logic [ACC_W-1:0]              num_mag;
    logic [ACC_W-1:0]              quot;
    logic signed [SAMPLE_BITS-1:0] n_y;
    logic                          n_sat;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (r_term)
            TERM_B0: begin op_coef = r_b0; op_sample = r_x;  op_sub = 1'b0; end
            TERM_B1: begin op_coef = r_b1; op_sample = r_x1; op_sub = 1'b0; end
            TERM_B2: begin op_coef = r_b2; op_sample = r_x2; op_sub = 1'b0; end
            TERM_A1: begin op_coef = r_a1; op_sample = r_y1; op_sub = 1'b1; end
            TERM_A2: begin op_coef = r_a2; op_sample = r_y2; op_sub = 1'b1; end
            default: begin op_coef = r_b0; op_sample = r_x;  op_sub = 1'b0; end
        endcase
    end

    // accumulate with saturation at the accumulator width
    always_comb begin
        sum = op_sub ? (SW'(r_acc) - SW'(mul_product)) : (SW'(r_acc) + SW'(mul_product));
        if (sum[SW-1] != sum[SW-2]) begin
            n_acc = sum[SW-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_acc = sum[ACC_W-1:0];
        end
    end

    always_comb begin
        dv      = (r_a0 == '0) ? CW'(COEF_ONE) : r_a0;
        den_mag = dv[CW-1] ? CW'(-dv) : dv;
        num_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : r_acc;
    end

    // quotient magnitude to signed sample with clipping
    always_comb begin
        if (r_qneg) begin
            n_sat = (quot > NEG_LIM);
            n_y   = n_sat ? SMIN : SAMPLE_BITS'(-quot);
        end else begin
            n_sat = (quot > POS_LIM);
            n_y   = n_sat ? SMAX : quot[SAMPLE_BITS-1:0];
        end
    end

    bqd_serial_mul #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .CW         (CW)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  ((r_state == ST_MUL) && r_kick),
        .i_coef   (op_coef),
        .i_sample (op_sample),
        .o_stat   (mul_stat),
        .o_product(mul_product)
    );

    bqd_serial_div #(
        .NUM_W(ACC_W),
        .DEN_W(CW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start((r_state == ST_DIV) && r_kick),
        .i_num  (num_mag),
        .i_den  (den_mag),
        .o_stat (div_stat),
        .o_quot (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kick      <= 1'b0;
            r_term      <= TERM_B0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_action == ACT_CLEAR) begin
                            r_x1 <= '0;
                            r_x2 <= '0;
                            r_y1 <= '0;
                            r_y2 <= '0;
                        end else if (!r_enable) begin
                            r_y     <= i_sample_in;
                            r_sat   <= 1'b0;
                            r_state <= ST_DONE;
                        end else begin
                            r_x     <= i_sample_in;
                            r_acc   <= '0;
                            r_term  <= TERM_B0;
                            r_kick  <= 1'b1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_kick <= mul_stat.done;
                    if (mul_stat.done) begin
                        r_acc <= n_acc;
                        if (r_term == TERM_A2) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_term <= r_term + 1'b1;
                        end
                    end
                end
                ST_DIV: begin
                    r_kick <= 1'b0;
                    if (r_kick) begin
                        r_qneg <= r_acc[ACC_W-1] ^ dv[CW-1];
                    end
                    if (div_stat.done) begin
                        r_y     <= n_y;
                        r_sat   <= n_sat;
                        r_x2    <= r_x1;
                        r_x1    <= r_x;
                        r_y2    <= r_y1;
                        r_y1    <= n_y;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_sample <= r_y;
                        r_out_sat    <= r_sat;
                        r_out_valid  <= 1'b1;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_saturated  = r_out_sat;

`include "assert_macros.svh"

    `BQD_ASSERT(a_idle_units_quiet, i_clk, i_rst_n, o_in_ready |-> !(mul_stat.busy || div_stat.busy), "arithmetic unit busy while accepting")
    `BQD_ASSERT(a_clear_no_work, i_clk, i_rst_n, (in_acc && i_action == ACT_CLEAR) |=> o_in_ready, "clear word started work")
    `BQD_NEVER(a_sat_value, i_clk, i_rst_n, o_out_valid && o_saturated && o_sample_out != SMAX && o_sample_out != SMIN, "saturated flag without a clipped value")

endmodule
